[design/bank_mapper_scanline_irq_assert.svh]
// Assertion macros shared by the bank mapper checker.
`ifndef BANK_MAPPER_SCANLINE_IRQ_ASSERT_SVH
`define BANK_MAPPER_SCANLINE_IRQ_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BMSI_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bank mapper check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define BMSI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bank mapper check failed");

`endif

[design/bmsi_pkg.sv]
// Shared types, codes and constants of the bank mapper.
`default_nettype none

package bmsi_pkg;

    localparam int REGISTER_COUNT = 16;
    localparam int RegAw = $clog2(REGISTER_COUNT);

    typedef logic [3:0] reg_idx_t;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_CLOCK = 2'd1,
        OP_PRG   = 2'd2,
        OP_CHR   = 2'd3
    } op_t;

    localparam logic [15:0] DECODE_MASK   = 16'hE001;
    localparam logic [15:0] WR_SELECT     = 16'h8000;
    localparam logic [15:0] WR_BANK_DATA  = 16'h8001;
    localparam logic [15:0] WR_MIRROR     = 16'hA000;
    localparam logic [15:0] WR_RAM_CTL    = 16'hA001;
    localparam logic [15:0] WR_RELOAD_VAL = 16'hC000;
    localparam logic [15:0] WR_RELOAD_REQ = 16'hC001;
    localparam logic [15:0] WR_IRQ_ACK    = 16'hE000;
    localparam logic [15:0] WR_IRQ_EN     = 16'hE001;

    localparam logic [2:0] CFG_CHIP_VARIANT = 3'd0;
    localparam logic [2:0] CFG_INDEX_MASK   = 3'd1;
    localparam logic [2:0] CFG_PRG_AND      = 3'd2;
    localparam logic [2:0] CFG_PRG_OR       = 3'd3;
    localparam logic [2:0] CFG_CHR_AND      = 3'd4;
    localparam logic [2:0] CFG_CHR_OR       = 3'd5;

    localparam logic [7:0] PRG_FIXED_BANK = 8'hFE;
    localparam int         PRG_MODE_BIT   = 6;
    localparam int         CHR_MODE_BIT   = 7;
    localparam logic [3:0] PRG_REG_BASE   = 4'd6;

    typedef struct packed {
        logic       prg_mode;
        logic       chr_mode;
        logic [9:0] prg_and;
        logic [9:0] prg_or;
        logic [9:0] chr_and;
        logic [9:0] chr_or;
    } xcfg_t;

    typedef struct packed {
        logic irq;
        logic mirror;
        logic ram_rd;
        logic ram_wr;
    } flags_t;

    function automatic logic [7:0] bank_reset_value(input int unsigned i);
        logic [7:0] v;
        case (i)
            0:       v = 8'd0;
            1:       v = 8'd2;
            2:       v = 8'd4;
            3:       v = 8'd5;
            4:       v = 8'd6;
            5:       v = 8'd7;
            6:       v = 8'd0;
            7:       v = 8'd1;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[design/bmsi_state.sv]
// Mapper state: configuration, bank registers, register write decode and scanline counter.
`default_nettype none

module bmsi_state
    import bmsi_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_write_enable,
    input  wire logic [2:0] cfg_index,
    input  wire logic [9:0] cfg_data,
    input  wire logic       fire,
    input  wire op_t        op,
    input  wire logic [15:0] address,
    input  wire logic [7:0] write_data,
    input  wire reg_idx_t   rd_idx,
    output logic [7:0]      rd_data,
    output xcfg_t           xcfg,
    output flags_t          flags_next
);

    logic       variant_reg;
    logic [3:0] index_mask_reg;
    logic [9:0] prg_and_reg;
    logic [9:0] prg_or_reg;
    logic [9:0] chr_and_reg;
    logic [9:0] chr_or_reg;

    logic [7:0] bank_regs_reg [REGISTER_COUNT];
    logic [7:0] bank_select_reg, bank_select_next;
    logic       mirror_reg, mirror_next;
    logic [1:0] ram_ctl_reg, ram_ctl_next;
    logic [7:0] reload_reg, reload_next;
    logic       reload_req_reg, reload_req_next;
    logic       irq_en_reg, irq_en_next;
    logic [7:0] counter_reg, counter_next;
    logic       irq_reg, irq_next;

    logic       bank_we;
    reg_idx_t   bank_widx;
    logic [15:0] wr_code;

    assign wr_code   = address & DECODE_MASK;
    assign bank_widx = bank_select_reg[3:0] & index_mask_reg;

    always_comb
    begin
        bank_select_next = bank_select_reg;
        mirror_next      = mirror_reg;
        ram_ctl_next     = ram_ctl_reg;
        reload_next      = reload_reg;
        reload_req_next  = reload_req_reg;
        irq_en_next      = irq_en_reg;
        counter_next     = counter_reg;
        irq_next         = irq_reg;
        bank_we          = 1'b0;
        if (fire)
        begin
            case (op)
                OP_WRITE:
                begin
                    case (wr_code)
                        WR_SELECT:     bank_select_next = write_data;
                        WR_BANK_DATA:  bank_we = ({1'b0, bank_widx} < 5'(REGISTER_COUNT));
                        WR_MIRROR:     mirror_next = write_data[0];
                        WR_RAM_CTL:    ram_ctl_next = write_data[7:6];
                        WR_RELOAD_VAL: reload_next = write_data;
                        WR_RELOAD_REQ:
                        begin
                            reload_req_next = 1'b1;
                            counter_next    = 8'd0;
                        end
                        WR_IRQ_ACK:
                        begin
                            irq_next    = 1'b0;
                            irq_en_next = 1'b0;
                        end
                        WR_IRQ_EN:     irq_en_next = 1'b1;
                        default:       ;
                    endcase
                end
                OP_CLOCK:
                begin
                    if (reload_req_reg || counter_reg == 8'd0)
                    begin
                        counter_next = reload_reg;
                    end
                    else
                    begin
                        counter_next = counter_reg - 8'd1;
                    end
                    if ((counter_reg != 8'd0 || !variant_reg || reload_req_reg)
                        && counter_next == 8'd0 && irq_en_reg)
                    begin
                        irq_next = 1'b1;
                    end
                    reload_req_next = 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            variant_reg    <= 1'b0;
            index_mask_reg <= 4'd7;
            prg_and_reg    <= 10'h3FF;
            prg_or_reg     <= 10'h000;
            chr_and_reg    <= 10'h3FF;
            chr_or_reg     <= 10'h000;
        end
        else if (cfg_write_enable)
        begin
            case (cfg_index)
                CFG_CHIP_VARIANT: variant_reg    <= cfg_data[0];
                CFG_INDEX_MASK:   index_mask_reg <= cfg_data[3:0];
                CFG_PRG_AND:      prg_and_reg    <= cfg_data;
                CFG_PRG_OR:       prg_or_reg     <= cfg_data;
                CFG_CHR_AND:      chr_and_reg    <= cfg_data;
                CFG_CHR_OR:       chr_or_reg     <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REGISTER_COUNT; i++)
            begin
                bank_regs_reg[i] <= bank_reset_value(i);
            end
            bank_select_reg <= 8'd0;
            mirror_reg      <= 1'b0;
            ram_ctl_reg     <= 2'd0;
            reload_reg      <= 8'd0;
            reload_req_reg  <= 1'b0;
            irq_en_reg      <= 1'b0;
            counter_reg     <= 8'd0;
            irq_reg         <= 1'b0;
        end
        else
        begin
            if (bank_we)
            begin
                bank_regs_reg[bank_widx[RegAw-1:0]] <= write_data;
            end
            bank_select_reg <= bank_select_next;
            mirror_reg      <= mirror_next;
            ram_ctl_reg     <= ram_ctl_next;
            reload_reg      <= reload_next;
            reload_req_reg  <= reload_req_next;
            irq_en_reg      <= irq_en_next;
            counter_reg     <= counter_next;
            irq_reg         <= irq_next;
        end
    end

    assign rd_data = ({1'b0, rd_idx} < 5'(REGISTER_COUNT))
                   ? bank_regs_reg[rd_idx[RegAw-1:0]] : 8'd0;

    assign xcfg.prg_mode = bank_select_reg[PRG_MODE_BIT];
    assign xcfg.chr_mode = bank_select_reg[CHR_MODE_BIT];
    assign xcfg.prg_and  = prg_and_reg;
    assign xcfg.prg_or   = prg_or_reg;
    assign xcfg.chr_and  = chr_and_reg;
    assign xcfg.chr_or   = chr_or_reg;

    assign flags_next.irq    = irq_next;
    assign flags_next.mirror = mirror_next;
    assign flags_next.ram_rd = ram_ctl_next[1];
    assign flags_next.ram_wr = ram_ctl_next[1] & ~ram_ctl_next[0];

endmodule

`default_nettype wire

[design/bmsi_xlate.sv]
// Program and graphics address translation through the bank registers and board masks.
`default_nettype none

module bmsi_xlate
    import bmsi_pkg::*;
(
    input  wire op_t         op,
    input  wire logic [15:0] address,
    input  wire xcfg_t       xcfg,
    input  wire logic [7:0]  rd_data,
    output reg_idx_t         rd_idx,
    output logic [9:0]       bank
);

    logic [1:0] prg_slot;
    logic [2:0] chr_slot;
    logic [2:0] chr_hi_idx;
    logic [7:0] raw;

    always_comb
    begin
        prg_slot = address[14:13];
        if (xcfg.prg_mode && !prg_slot[0])
        begin
            prg_slot[1] = ~prg_slot[1];
        end
        chr_slot = address[12:10];
        if (xcfg.chr_mode)
        begin
            chr_slot[2] = ~chr_slot[2];
        end
        chr_hi_idx = chr_slot - 3'd2;

        if (op == OP_PRG)
        begin
            rd_idx = PRG_REG_BASE | {3'b000, prg_slot[0]};
        end
        else if (chr_slot[2])
        begin
            rd_idx = {1'b0, chr_hi_idx};
        end
        else
        begin
            rd_idx = {3'b000, chr_slot[1]};
        end

        raw  = 8'd0;
        bank = 10'd0;
        case (op)
            OP_PRG:
            begin
                raw  = prg_slot[1] ? (PRG_FIXED_BANK | {7'd0, prg_slot[0]}) : rd_data;
                bank = ({2'b00, raw} & xcfg.prg_and) | xcfg.prg_or;
            end
            OP_CHR:
            begin
                raw  = chr_slot[2] ? rd_data : {rd_data[7:1], chr_slot[0]};
                bank = ({2'b00, raw} & xcfg.chr_and) | xcfg.chr_or;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

[design/bank_mapper_scanline_irq.sv]
// Top level of the bank mapper with scanline interrupt counter.
//
// Each input word is one operation: a CPU register write, a scanline clock, a program
// address translation or a graphics address translation. A word sits in the input
// register, where its decode, state update and translation are done, and is then held
// in the result register until taken. One word is taken every clock while results
// drain; the update of the mapper state sets that rate. Every result carries the
// translated bank (zero for writes and clocks) and the interrupt, mirroring and work
// RAM flags as they stand after the operation. Configuration writes land at once; the
// user must make them while no word is in flight, as the block does not enforce it.
`default_nettype none

module bank_mapper_scanline_irq
    import bmsi_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_write_enable,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [9:0]  cfg_data,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  operation,
    input  wire logic [15:0] address,
    input  wire logic [7:0]  write_data,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [9:0]       bank_number,
    output logic             irq_pending,
    output logic             mirror_horizontal,
    output logic             ram_read_enable,
    output logic             ram_write_enable
);

    logic        s1_valid_reg;
    op_t         s1_op_reg;
    logic [15:0] s1_addr_reg;
    logic [7:0]  s1_data_reg;

    logic        out_valid_reg;
    logic [9:0]  bank_reg;
    flags_t      flags_reg;

    logic        advance;
    logic        accept;
    logic        fire;

    reg_idx_t    rd_idx;
    logic [7:0]  rd_data;
    xcfg_t       xcfg;
    flags_t      flags_next;
    logic [9:0]  bank_calc;

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;
    assign fire     = s1_valid_reg && advance;

    bmsi_state u_state (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .fire             (fire),
        .op               (s1_op_reg),
        .address          (s1_addr_reg),
        .write_data       (s1_data_reg),
        .rd_idx           (rd_idx),
        .rd_data          (rd_data),
        .xcfg             (xcfg),
        .flags_next       (flags_next)
    );

    bmsi_xlate u_xlate (
        .op      (s1_op_reg),
        .address (s1_addr_reg),
        .xcfg    (xcfg),
        .rd_data (rd_data),
        .rd_idx  (rd_idx),
        .bank    (bank_calc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // hold payloads until the next word moves in
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg   <= op_t'(operation);
            s1_addr_reg <= address;
            s1_data_reg <= write_data;
        end
        if (fire)
        begin
            bank_reg  <= bank_calc;
            flags_reg <= flags_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign bank_number       = bank_reg;
    assign irq_pending       = flags_reg.irq;
    assign mirror_horizontal = flags_reg.mirror;
    assign ram_read_enable   = flags_reg.ram_rd;
    assign ram_write_enable  = flags_reg.ram_wr;

endmodule

`default_nettype wire

[design/bmsi_checker.sv]
// Port-level checker of the bank mapper and its bind to the top level.
`default_nettype none

`include "bank_mapper_scanline_irq_assert.svh"

module bmsi_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [9:0] bank_number,
    input wire logic       irq_pending,
    input wire logic       mirror_horizontal,
    input wire logic       ram_read_enable,
    input wire logic       ram_write_enable
);

    logic [13:0] out_word;

    assign out_word = {bank_number, irq_pending, mirror_horizontal,
                       ram_read_enable, ram_write_enable};

    `BMSI_ASSERT_NEXT(a_out_valid_holds, out_valid && out_stall, out_valid)

    `BMSI_ASSERT_NEXT(a_out_word_holds, out_valid && out_stall, $stable(out_word))

    `BMSI_ASSERT_NOW(a_stall_only_when_full, in_stall, out_valid && out_stall)

    `BMSI_ASSERT_NOW(a_ram_write_needs_read, out_valid && ram_write_enable, ram_read_enable)

endmodule

bind bank_mapper_scanline_irq bmsi_checker u_bmsi_checker (.*);

`default_nettype wire
